@@ hdl/mmrc_pkg.sv @@
package mmrc_pkg;

  // Field widths
  localparam int unsigned TypeW     = 32;
  localparam int unsigned AddrW     = 64;
  localparam int unsigned SizeW     = 64;
  localparam int unsigned PagesW    = 52;
  localparam int unsigned PageShift = 12;
  localparam int unsigned ClassW    = 3;
  localparam int unsigned IndexW    = 7;

  localparam int unsigned MaxDescDefault = 128;

  // Output queue depth, power of two, at least 2
  localparam int unsigned OutDepth = 4;

  // Firmware memory type codes
  localparam logic [TypeW-1:0] MtReserved     = 32'd0;
  localparam logic [TypeW-1:0] MtLoaderCode   = 32'd1;
  localparam logic [TypeW-1:0] MtLoaderData   = 32'd2;
  localparam logic [TypeW-1:0] MtBootCode     = 32'd3;
  localparam logic [TypeW-1:0] MtBootData     = 32'd4;
  localparam logic [TypeW-1:0] MtRuntimeCode  = 32'd5;
  localparam logic [TypeW-1:0] MtRuntimeData  = 32'd6;
  localparam logic [TypeW-1:0] MtConventional = 32'd7;
  localparam logic [TypeW-1:0] MtAcpiReclaim  = 32'd9;
  localparam logic [TypeW-1:0] MtAcpiNvs      = 32'd10;
  localparam logic [TypeW-1:0] MtMmio         = 32'd11;
  localparam logic [TypeW-1:0] MtMmioPort     = 32'd12;
  localparam logic [TypeW-1:0] MtPalCode      = 32'd13;
  localparam logic [TypeW-1:0] MtOemBase      = 32'h8000_0000;

  typedef enum logic [ClassW-1:0] {
    ClsNone     = 3'd0,
    ClsRam      = 3'd1,
    ClsReserved = 3'd2,
    ClsAcpi     = 3'd3,
    ClsNvs      = 3'd4,
    ClsUnusable = 3'd5
  } class_e;

  typedef struct packed {
    logic [TypeW-1:0]  mem_type;
    logic [AddrW-1:0]  phys_start;
    logic [PagesW-1:0] page_count;
    logic              map_end;
  } desc_t;

  typedef struct packed {
    logic [AddrW-1:0]  region_addr;
    logic [SizeW-1:0]  region_size;
    class_e            region_class;
    logic [IndexW-1:0] region_index;
    logic              final_region;
    logic              map_too_long;
  } region_t;

  // Up to two results written into the output queue per descriptor
  typedef struct packed {
    logic [1:0] cnt;
    region_t    r0;
    region_t    r1;
  } push_t;

  function automatic class_e mmrc_classify(logic [TypeW-1:0] t, logic rt_reserved);
    class_e c;
    case (t)
      MtReserved, MtPalCode:       c = ClsReserved;
      MtRuntimeCode, MtRuntimeData: c = rt_reserved ? ClsReserved : ClsRam;
      MtAcpiReclaim:               c = ClsAcpi;
      MtAcpiNvs:                   c = ClsNvs;
      MtLoaderCode, MtLoaderData, MtBootCode, MtBootData, MtConventional:
                                   c = ClsRam;
      MtMmio, MtMmioPort:          c = ClsNone;
      default:                     c = (t >= MtOemBase) ? ClsRam : ClsUnusable;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/mmrc_if.sv @@
interface mmrc_desc_if;
  import mmrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [TypeW-1:0]  mem_type;
  logic [AddrW-1:0]  phys_start;
  logic [PagesW-1:0] page_count;
  logic              map_end;
  modport source (output valid, mem_type, phys_start, page_count, map_end, input ready);
  modport sink   (input valid, mem_type, phys_start, page_count, map_end, output ready);
endinterface

interface mmrc_cfg_if;
  logic valid;
  logic ready;
  logic runtime_as_reserved;
  modport source (output valid, runtime_as_reserved, input ready);
  modport sink   (input valid, runtime_as_reserved, output ready);
endinterface

interface mmrc_region_if;
  import mmrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  region_addr;
  logic [SizeW-1:0]  region_size;
  logic [ClassW-1:0] region_class;
  logic [IndexW-1:0] region_index;
  logic              final_region;
  logic              map_too_long;
  modport source (output valid, region_addr, region_size, region_class, region_index,
                  final_region, map_too_long, input ready);
  modport sink   (input valid, region_addr, region_size, region_class, region_index,
                  final_region, map_too_long, output ready);
endinterface

@@ hdl/memory_map_region_coalescer.sv @@
// Memory map region coalescer. Each transfer on desc_i is one firmware memory
// descriptor; its type is mapped to a legacy class (RAM, reserved, ACPI, NVS,
// unusable) and I/O types are dropped. A single pending region is held and grown
// while descriptors of the same class start exactly at its end; otherwise the
// pending region goes out on region_o with its table index and a new one opens.
// The map_end descriptor flushes the pending region marked final_region, or emits
// one empty final marker if the map gave no region. A map of more than
// MaxDescriptors descriptors ends in a single map_too_long result, and earlier
// regions of that map must be dropped by the consumer. Rate: one descriptor per
// clock while the output queue has room for two results; a descriptor is held in
// the input register, and its results are written from there into the output
// queue, whose head is offered on region_o. A descriptor can produce two results
// while region_o moves one per clock, so sustained rate is set by the output side:
// the four-entry output queue accepts a descriptor whenever it has room for two
// results. runtime_as_reserved is written through cfg_i (always ready); the user
// must write it only while the block is idle, which the block does not enforce.
module memory_map_region_coalescer #(
  parameter int unsigned MaxDescriptors = mmrc_pkg::MaxDescDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mmrc_desc_if.sink     desc_i,
  mmrc_cfg_if.sink      cfg_i,
  mmrc_region_if.source region_o
);
  import mmrc_pkg::*;

  logic  rt_reserved_q;
  logic  room2;
  push_t push;

  // config register, single bit, no address
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_reserved_q <= 1'b0;
    end else if (cfg_i.valid) begin
      rt_reserved_q <= cfg_i.runtime_as_reserved;
    end
  end

  // classify, merge and emit
  mmrc_core #(
    .MaxDesc (MaxDescriptors)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rt_reserved_i (rt_reserved_q),
    .room2_i       (room2),
    .desc_i        (desc_i),
    .push_o        (push)
  );

  // result queue toward region_o
  mmrc_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .room2_o  (room2),
    .region_o (region_o)
  );

endmodule

@@ hdl/mmrc_core.sv @@
module mmrc_core #(
  parameter int unsigned MaxDesc = mmrc_pkg::MaxDescDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rt_reserved_i,
  input  logic            room2_i,
  mmrc_desc_if.sink       desc_i,
  output mmrc_pkg::push_t push_o
);
  import mmrc_pkg::*;

  localparam int unsigned SeenW = $clog2(MaxDesc + 2);

  // input register
  logic  iv_q, iv_d;
  desc_t item_q;
  logic  take, drain;

  // pending region
  logic              pv_q, pv_d;
  logic [AddrW-1:0]  paddr_q, paddr_d;
  logic [SizeW-1:0]  psize_q, psize_d;
  logic [AddrW-1:0]  pend_q, pend_d;   // paddr + psize, kept for the adjacency test
  class_e            pcls_q, pcls_d;
  logic [IndexW-1:0] ridx_q, ridx_d;
  logic [SeenW-1:0]  seen_q, seen_d;

  logic              over, ext;
  class_e            cls;
  logic [SizeW-1:0]  size;
  region_t           fin;
  push_t             push;

  assign drain        = iv_q && room2_i;
  assign desc_i.ready = !iv_q || drain;
  assign take         = desc_i.valid && desc_i.ready;
  assign push_o       = push;

  always_comb begin
    iv_d = iv_q;
    if (take) begin
      iv_d = 1'b1;
    end else if (drain) begin
      iv_d = 1'b0;
    end
  end

  always_comb begin
    over = seen_q >= SeenW'(MaxDesc);
    cls  = mmrc_classify(item_q.mem_type, rt_reserved_i);
    size = {item_q.page_count, {PageShift{1'b0}}};
    ext  = pv_q && (cls != ClsNone) && (cls == pcls_q) && (pend_q == item_q.phys_start);

    pv_d    = pv_q;
    paddr_d = paddr_q;
    psize_d = psize_q;
    pend_d  = pend_q;
    pcls_d  = pcls_q;
    ridx_d  = ridx_q;
    seen_d  = seen_q;
    fin     = '0;
    push    = '0;

    if (drain) begin
      if (seen_q <= SeenW'(MaxDesc)) begin
        seen_d = seen_q + SeenW'(1);
      end
      if (over) begin
        // past the limit: swallow, one error result at map end
        if (item_q.map_end) begin
          push.cnt             = 2'd1;
          push.r0.final_region = 1'b1;
          push.r0.map_too_long = 1'b1;
          pv_d   = 1'b0;
          ridx_d = '0;
          seen_d = '0;
        end
      end else begin
        if (cls != ClsNone) begin
          if (ext) begin
            psize_d = psize_q + size;
            pend_d  = pend_q + size;
          end else begin
            if (pv_q) begin
              push.cnt             = 2'd1;
              push.r0.region_addr  = paddr_q;
              push.r0.region_size  = psize_q;
              push.r0.region_class = pcls_q;
              push.r0.region_index = ridx_q;
              ridx_d               = ridx_q + IndexW'(1);
            end
            pv_d    = 1'b1;
            paddr_d = item_q.phys_start;
            psize_d = size;
            pend_d  = item_q.phys_start + size;
            pcls_d  = cls;
          end
        end
        if (item_q.map_end) begin
          // flush, or empty marker when nothing was produced
          fin.final_region = 1'b1;
          if (pv_d) begin
            fin.region_addr  = paddr_d;
            fin.region_size  = psize_d;
            fin.region_class = pcls_d;
            fin.region_index = ridx_d;
          end
          if (push.cnt == 2'd0) begin
            push.r0 = fin;
          end else begin
            push.r1 = fin;
          end
          push.cnt = push.cnt + 2'd1;
          pv_d     = 1'b0;
          ridx_d   = '0;
          seen_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q   <= 1'b0;
      pv_q   <= 1'b0;
      ridx_q <= '0;
      seen_q <= '0;
    end else begin
      iv_q   <= iv_d;
      pv_q   <= pv_d;
      ridx_q <= ridx_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.mem_type   <= desc_i.mem_type;
      item_q.phys_start <= desc_i.phys_start;
      item_q.page_count <= desc_i.page_count;
      item_q.map_end    <= desc_i.map_end;
    end
    paddr_q <= paddr_d;
    psize_q <= psize_d;
    pend_q  <= pend_d;
    pcls_q  <= pcls_d;
  end

`ifndef NO_ASSERTIONS
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenW'(MaxDesc + 1))
    else $error("descriptor count past saturation");

  a_push_only_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> drain)
    else $error("result pushed without a descriptor");

  a_map_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain && item_q.map_end) |=> (!pv_q && seen_q == '0 && ridx_q == '0))
    else $error("map state not cleared after last descriptor");
`endif

endmodule

@@ hdl/mmrc_outq.sv @@
module mmrc_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mmrc_pkg::push_t push_i,
  output logic            room2_o,
  mmrc_region_if.source   region_o
);
  import mmrc_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  region_t         ent_q [OutDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q, free;
  logic            pop;
  region_t         head;

  assign head    = ent_q[rptr_q];
  assign pop     = region_o.valid && region_o.ready;
  assign free    = CntW'(OutDepth) - cnt_q;
  assign room2_o = free >= CntW'(2);

  assign region_o.valid        = cnt_q != '0;
  assign region_o.region_addr  = head.region_addr;
  assign region_o.region_size  = head.region_size;
  assign region_o.region_class = head.region_class;
  assign region_o.region_index = head.region_index;
  assign region_o.final_region = head.final_region;
  assign region_o.map_too_long = head.map_too_long;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + PtrW'(push_i.cnt);
      rptr_q <= rptr_q + PtrW'(pop);
      cnt_q  <= cnt_q + CntW'(push_i.cnt) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      ent_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      ent_q[wptr_q + PtrW'(1)] <= push_i.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(push_i.cnt) <= free)
    else $error("output queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(OutDepth))
    else $error("output queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[PtrW-1:0] == PtrW'(wptr_q - rptr_q))
    else $error("output queue pointers disagree with count");
`endif

endmodule

@@ dv/memory_map_region_coalescer_tb.sv @@
`timescale 1ns / 1ps

module memory_map_region_coalescer_tb;
  import mmrc_pkg::*;

  localparam int unsigned MaxDesc    = MaxDescDefault;
  localparam int unsigned SettleCyc  = 8;     // covers the input register plus queue slack
  localparam int unsigned StallLimit = 2000;  // cycles without any transfer
  localparam int unsigned ItemTarget = 1350;

  // Type codes the package leaves unnamed; both classify as unusable.
  localparam logic [TypeW-1:0] MtUnlisted       = 32'd8;
  localparam logic [TypeW-1:0] MtFirstUndefined = 32'd14;

  typedef enum int unsigned {
    MapChained,  // contiguous ranges, repeated types: exercises merging
    MapScatter,  // never contiguous, never dropped: one region per descriptor
    MapNoise     // everything random
  } map_style_e;

  logic clk;
  logic rst_n;

  mmrc_desc_if   desc_if ();
  mmrc_cfg_if    cfg_if ();
  mmrc_region_if region_if ();

  memory_map_region_coalescer dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .desc_i  (desc_if),
    .cfg_i   (cfg_if),
    .region_o(region_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Coalescing predictor: own copy of the pending region and map counters.
  // ---------------------------------------------------------------------------
  logic              rt_reserved = 1'b0;
  logic              cur_valid;
  logic [AddrW-1:0]  cur_addr;
  logic [SizeW-1:0]  cur_size;
  class_e            cur_class;
  logic [7:0]        table_index;
  logic [8:0]        map_desc_count;

  region_t           want_regions[$];

  int unsigned       sent_count      = 0;
  int unsigned       maps_done       = 0;
  int unsigned       empty_maps      = 0;
  int unsigned       too_long_maps   = 0;
  int unsigned       results_checked = 0;
  int unsigned       errors          = 0;

  function automatic class_e legacy_class(logic [TypeW-1:0] t);
    class_e c;
    if (t >= MtOemBase) begin
      c = ClsRam;  // vendor-defined range
    end else begin
      case (t)
        MtReserved, MtPalCode:         c = ClsReserved;
        MtRuntimeCode, MtRuntimeData:  c = rt_reserved ? ClsReserved : ClsRam;
        MtLoaderCode, MtLoaderData, MtBootCode, MtBootData, MtConventional:
                                       c = ClsRam;
        MtAcpiReclaim:                 c = ClsAcpi;
        MtAcpiNvs:                     c = ClsNvs;
        MtMmio, MtMmioPort:            c = ClsNone;
        default:                       c = ClsUnusable;
      endcase
    end
    return c;
  endfunction

  function automatic region_t region_of(logic [AddrW-1:0] addr, logic [SizeW-1:0] size,
                                        class_e cls, logic [IndexW-1:0] idx,
                                        logic fin, logic err);
    region_t r;
    r.region_addr  = addr;
    r.region_size  = size;
    r.region_class = cls;
    r.region_index = idx;
    r.final_region = fin;
    r.map_too_long = err;
    return r;
  endfunction

  task automatic close_map();
    cur_valid      = 1'b0;
    cur_addr       = '0;
    cur_size       = '0;
    cur_class      = ClsNone;
    table_index    = '0;
    map_desc_count = '0;
    maps_done++;
  endtask

  task automatic coalesce_descriptor(input desc_t d);
    class_e           cls;
    logic [SizeW-1:0] bytes;
    // count saturates one past the limit
    if (map_desc_count <= MaxDesc) map_desc_count++;
    if (map_desc_count > MaxDesc) begin
      // over the limit: swallowed; the closing descriptor reports the error alone
      if (d.map_end) begin
        want_regions.push_back(region_of('0, '0, ClsNone, '0, 1'b1, 1'b1));
        too_long_maps++;
        close_map();
      end
    end else begin
      cls   = legacy_class(d.mem_type);
      bytes = {d.page_count, {PageShift{1'b0}}};  // pages * 4096
      if (cls != ClsNone) begin
        if (cur_valid && cur_class == cls && cur_addr + cur_size == d.phys_start) begin
          cur_size += bytes;
        end else begin
          if (cur_valid) begin
            want_regions.push_back(region_of(cur_addr, cur_size, cur_class,
                                             table_index[IndexW-1:0], 1'b0, 1'b0));
            table_index++;
          end
          cur_valid = 1'b1;
          cur_addr  = d.phys_start;
          cur_size  = bytes;
          cur_class = cls;
        end
      end
      if (d.map_end) begin
        if (cur_valid) begin
          want_regions.push_back(region_of(cur_addr, cur_size, cur_class,
                                           table_index[IndexW-1:0], 1'b1, 1'b0));
        end else begin
          // map gave no region at all: single empty marker
          want_regions.push_back(region_of('0, '0, ClsNone, '0, 1'b1, 1'b0));
          empty_maps++;
        end
        close_map();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each region transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_regions
    region_t w;
    if (rst_n && region_if.valid === 1'b1 && region_if.ready === 1'b1) begin
      if (want_regions.size() == 0) begin
        $error("region with nothing expected: addr %h size %h class %0d",
               region_if.region_addr, region_if.region_size, region_if.region_class);
        errors++;
      end else begin
        w = want_regions.pop_front();
        results_checked++;
        if (region_if.region_addr !== w.region_addr) begin
          $error("region_addr: expected %h, got %h", w.region_addr, region_if.region_addr);
          errors++;
        end
        if (region_if.region_size !== w.region_size) begin
          $error("region_size: expected %h, got %h", w.region_size, region_if.region_size);
          errors++;
        end
        if (region_if.region_class !== w.region_class) begin
          $error("region_class: expected %0d, got %0d", w.region_class,
                 region_if.region_class);
          errors++;
        end
        if (region_if.region_index !== w.region_index) begin
          $error("region_index: expected %0d, got %0d", w.region_index,
                 region_if.region_index);
          errors++;
        end
        if (region_if.final_region !== w.final_region) begin
          $error("final_region: expected %b, got %b", w.final_region,
                 region_if.final_region);
          errors++;
        end
        if (region_if.map_too_long !== w.map_too_long) begin
          $error("map_too_long: expected %b, got %b", w.map_too_long,
                 region_if.map_too_long);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any transfer on any channel restarts the count.
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((desc_if.valid === 1'b1 && desc_if.ready === 1'b1) ||
        (region_if.valid === 1'b1 && region_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d regions outstanding",
               quiet_cycles, want_regions.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a 16-bit mask that repeats until it is redrawn. Bit 0 is
  // forced high so that no stall lasts through a whole pass of the mask.
  // ---------------------------------------------------------------------------
  initial begin : region_receiver
    logic [15:0] mask;
    region_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      case ($urandom_range(0, 3))
        0:       mask = '1;                           // full rate stretch
        1:       mask = 16'($urandom & $urandom);     // heavy back-pressure
        default: mask = 16'($urandom);
      endcase
      mask[0] = 1'b1;
      for (int k = 0; k < 64; k++) begin
        @(posedge clk);
        region_if.ready <= mask[k % 16];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them when enabled.
  // ---------------------------------------------------------------------------
  int unsigned burst_left   = 0;
  bit          gaps_enabled = 1'b1;

  task automatic send_descriptor(input desc_t d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_enabled && $urandom_range(0, 2) != 0) begin
        desc_if.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    desc_if.valid      <= 1'b1;
    desc_if.mem_type   <= d.mem_type;
    desc_if.phys_start <= d.phys_start;
    desc_if.page_count <= d.page_count;
    desc_if.map_end    <= d.map_end;
    do @(posedge clk); while (desc_if.ready !== 1'b1);
    coalesce_descriptor(d);
    sent_count++;
  endtask

  // Stop sending, let every predicted region arrive, then let dropped or
  // merged descriptors still in the pipe retire.
  task automatic wait_for_drain();
    desc_if.valid <= 1'b0;
    burst_left = 0;
    while (want_regions.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic write_runtime_as_reserved(input logic v);
    wait_for_drain();
    cfg_if.valid               <= 1'b1;
    cfg_if.runtime_as_reserved <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    rt_reserved = v;
  endtask

  function automatic desc_t mk_desc(logic [TypeW-1:0] t, logic [AddrW-1:0] start,
                                    logic [PagesW-1:0] pages, logic last);
    desc_t d;
    d.mem_type   = t;
    d.phys_start = start;
    d.page_count = pages;
    d.map_end    = last;
    return d;
  endfunction

  function automatic logic [TypeW-1:0] random_type();
    logic [TypeW-1:0] t;
    case ($urandom_range(0, 19))
      0, 1:    t = $urandom;
      2:       t = {1'b1, 31'($urandom)};
      3:       t = $urandom_range(0, 1) ? MtOemBase - 1 : '1;
      default: t = $urandom_range(0, 15);
    endcase
    return t;
  endfunction

  function automatic logic [PagesW-1:0] random_pages();
    logic [PagesW-1:0] p;
    case ($urandom_range(0, 9))
      0:       p = PagesW'({$urandom, $urandom});
      1:       p = '1;
      2:       p = '0;
      default: p = PagesW'($urandom_range(1, 64));
    endcase
    return p;
  endfunction

  task automatic send_map(input int unsigned len, input map_style_e style);
    desc_t            d;
    logic [AddrW-1:0] next_start;
    next_start = {$urandom, $urandom};
    d.mem_type = random_type();
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        MapChained: begin
          // half the time keep the type, mostly start where the last one ended
          if ($urandom_range(0, 1)) d.mem_type = random_type();
          d.phys_start = ($urandom_range(0, 4) != 0) ? next_start : {$urandom, $urandom};
        end
        MapScatter: begin
          d.mem_type = random_type();
          if (legacy_class(d.mem_type) == ClsNone) d.mem_type = MtConventional;
          d.phys_start = {$urandom, $urandom};
        end
        default: begin
          d.mem_type   = random_type();
          d.phys_start = {$urandom, $urandom};
        end
      endcase
      d.page_count = random_pages();
      d.map_end    = (i == len - 1);
      next_start   = d.phys_start + {d.page_count, {PageShift{1'b0}}};
      send_descriptor(d);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every named type code, unnamed codes, merges within a class, class changes,
  // address gaps, zero and full page counts, an end address that wraps past 2^64,
  // and a map closed by a dropped I/O descriptor.
  task automatic test_type_mapping();
    send_descriptor(mk_desc(MtConventional,   64'h0,       '0, 1'b0));
    send_descriptor(mk_desc(MtLoaderCode,     64'h0,        1, 1'b0));
    send_descriptor(mk_desc(MtLoaderData,     64'h1000,     2, 1'b0));
    send_descriptor(mk_desc(MtMmio,           '1,          '1, 1'b0));
    send_descriptor(mk_desc(MtBootCode,       64'h3000,     1, 1'b0));
    send_descriptor(mk_desc(MtBootData,       64'h8000,     1, 1'b0));
    send_descriptor(mk_desc(MtRuntimeCode,    64'h9000,     1, 1'b0));
    send_descriptor(mk_desc(MtRuntimeData,    64'ha000,     1, 1'b0));
    send_descriptor(mk_desc(MtReserved,       64'hb000,     1, 1'b0));
    send_descriptor(mk_desc(MtPalCode,        64'hc000,     1, 1'b0));
    send_descriptor(mk_desc(MtAcpiReclaim,    64'hd000,     4, 1'b0));
    send_descriptor(mk_desc(MtAcpiNvs,        64'h11000,   '1, 1'b0));
    send_descriptor(mk_desc(MtUnlisted,       64'h20000,    1, 1'b0));
    send_descriptor(mk_desc(MtFirstUndefined, 64'h21000,    1, 1'b0));
    send_descriptor(mk_desc(MtOemBase - 1,    64'h22000,    1, 1'b0));
    send_descriptor(mk_desc(MtOemBase,        64'hffff_ffff_ffff_f000, 2, 1'b0));
    send_descriptor(mk_desc('1,               64'h1000,     1, 1'b0));
    send_descriptor(mk_desc(MtMmioPort,       64'h0,       '0, 1'b1));
  endtask

  // Maps that yield no region: a lone I/O descriptor, and two in a row.
  task automatic test_empty_maps();
    send_descriptor(mk_desc(MtMmioPort, {$urandom, $urandom}, random_pages(), 1'b1));
    send_descriptor(mk_desc(MtMmio,     {$urandom, $urandom}, random_pages(), 1'b0));
    send_descriptor(mk_desc(MtMmioPort, {$urandom, $urandom}, random_pages(), 1'b1));
  endtask

  // With the switch set, run-time services merge with reserved memory.
  task automatic test_runtime_switch();
    write_runtime_as_reserved(1'b1);
    send_descriptor(mk_desc(MtRuntimeCode,  64'h4000_0000, 3, 1'b0));
    send_descriptor(mk_desc(MtRuntimeData,  64'h4000_3000, 1, 1'b0));
    send_descriptor(mk_desc(MtReserved,     64'h4000_4000, 1, 1'b0));
    send_descriptor(mk_desc(MtPalCode,      64'h4000_5000, 1, 1'b0));
    send_descriptor(mk_desc(MtConventional, 64'h4000_6000, 1, 1'b0));
    send_descriptor(mk_desc(MtRuntimeData,  64'h4000_7000, 1, 1'b1));
    write_runtime_as_reserved(1'b0);
  endtask

  // A full table (indexes up to the top), one over the limit, and a longer
  // overrun whose tail is swallowed.
  task automatic test_map_limit();
    send_map(MaxDesc, MapScatter);
    send_map(MaxDesc + 1, MapScatter);
    send_map(MaxDesc + 9, MapChained);
    wait_for_drain();
  endtask

  task automatic test_random_maps();
    int unsigned len;
    int unsigned pick;
    map_style_e  style;
    while (sent_count < ItemTarget) begin
      if ($urandom_range(0, 14) == 0) write_runtime_as_reserved(1'($urandom_range(0, 1)));
      gaps_enabled = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 85)      len = $urandom_range(1, 24);
      else if (pick < 97) len = $urandom_range(25, 64);
      else                len = $urandom_range(MaxDesc - 4, MaxDesc + 8);
      pick = $urandom_range(0, 99);
      if (pick < 70)      style = MapChained;
      else if (pick < 85) style = MapScatter;
      else                style = MapNoise;
      send_map(len, style);
    end
  endtask

  initial begin : stimulus
    desc_if.valid              <= 1'b0;
    desc_if.mem_type           <= '0;
    desc_if.phys_start         <= '0;
    desc_if.page_count         <= '0;
    desc_if.map_end            <= 1'b0;
    cfg_if.valid               <= 1'b0;
    cfg_if.runtime_as_reserved <= 1'b0;
    rst_n                      <= 1'b0;
    close_map();
    maps_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_type_mapping();
    test_empty_maps();
    test_runtime_switch();
    test_map_limit();
    test_random_maps();
    wait_for_drain();

    $display("covered %0d descriptors in %0d maps: %0d empty, %0d over the descriptor limit",
             sent_count, maps_done, empty_maps, too_long_maps);
    $display("%0d coalesced regions compared field by field", results_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/mmrc_pkg.sv
hdl/mmrc_if.sv
hdl/mmrc_core.sv
hdl/mmrc_outq.sv
hdl/memory_map_region_coalescer.sv
dv/memory_map_region_coalescer_tb.sv
